// ----- hdl/kts_pkg.sv -----
package kts_pkg;

   localparam int KEY_BITS  = 64;
   localparam int SIZE_BITS = 30;
   localparam int OP_BITS   = 3;
   localparam int ST_BITS   = 3;

   localparam logic [SIZE_BITS-1:0] SIZE_LIMIT = 30'd1000000000;

   localparam logic [OP_BITS-1:0] OP_INSERT = 3'd0;
   localparam logic [OP_BITS-1:0] OP_FIND   = 3'd1;
   localparam logic [OP_BITS-1:0] OP_GET    = 3'd2;
   localparam logic [OP_BITS-1:0] OP_SORT   = 3'd3;
   localparam logic [OP_BITS-1:0] OP_KSMALL = 3'd4;
   localparam logic [OP_BITS-1:0] OP_FILTER = 3'd5;
   localparam logic [OP_BITS-1:0] OP_CLEAR  = 3'd6;

   localparam logic [ST_BITS-1:0] ST_OK       = 3'd0;
   localparam logic [ST_BITS-1:0] ST_FULL     = 3'd1;
   localparam logic [ST_BITS-1:0] ST_DUP      = 3'd2;
   localparam logic [ST_BITS-1:0] ST_BADSIZE  = 3'd3;
   localparam logic [ST_BITS-1:0] ST_NOTFOUND = 3'd4;
   localparam logic [ST_BITS-1:0] ST_RANGE    = 3'd5;
   localparam logic [ST_BITS-1:0] ST_NONE     = 3'd6;

   // Per-cell command: the whole row acts on it in the same cycle.
   typedef struct packed {
      logic swap_pass;   // odd-even transposition step
      logic odd_phase;   // pairs start at odd slots
      logic write_en;    // load the new entry
   } cell_ctl_type;

endpackage

// ----- hdl/kts_cell.sv -----
// One table entry. Holds key, size, kind; compares its size with a neighbor's
// and joins an odd-even transposition with its left or right neighbor.
module kts_cell #(
   parameter int KIND_BITS = 3
) (
   input  logic                          clock,
   input  kts_pkg::cell_ctl_type         ctl,
   input  logic                          sel,        // this cell is the write target
   input  logic                          is_left,    // left member of a pair this phase
   input  logic                          is_right,   // right member of a pair this phase
   input  logic [kts_pkg::KEY_BITS-1:0]  wr_key,
   input  logic [kts_pkg::SIZE_BITS-1:0] wr_size,
   input  logic [KIND_BITS-1:0]          wr_kind,
   input  logic [kts_pkg::KEY_BITS-1:0]  nbr_r_key,
   input  logic [kts_pkg::SIZE_BITS-1:0] nbr_r_size,
   input  logic [KIND_BITS-1:0]          nbr_r_kind,
   input  logic [kts_pkg::KEY_BITS-1:0]  nbr_l_key,
   input  logic [kts_pkg::SIZE_BITS-1:0] nbr_l_size,
   input  logic [KIND_BITS-1:0]          nbr_l_kind,
   output logic [kts_pkg::KEY_BITS-1:0]  key_q,
   output logic [kts_pkg::SIZE_BITS-1:0] size_q,
   output logic [KIND_BITS-1:0]          kind_q
);
   import kts_pkg::*;

   logic [KEY_BITS-1:0]  key_ff,  key_in;
   logic [SIZE_BITS-1:0] size_ff, size_in;
   logic [KIND_BITS-1:0] kind_ff, kind_in;
   logic swap_r, swap_l;

   // Pair swaps when left size is strictly larger: equal sizes stay put.
   assign swap_r = is_left  && (size_ff > nbr_r_size);
   assign swap_l = is_right && (nbr_l_size > size_ff);

   always_comb begin
      key_in  = key_ff;
      size_in = size_ff;
      kind_in = kind_ff;
      if (ctl.write_en && sel) begin
         key_in  = wr_key;
         size_in = wr_size;
         kind_in = wr_kind;
      end else if (ctl.swap_pass && swap_r) begin
         key_in  = nbr_r_key;
         size_in = nbr_r_size;
         kind_in = nbr_r_kind;
      end else if (ctl.swap_pass && swap_l) begin
         key_in  = nbr_l_key;
         size_in = nbr_l_size;
         kind_in = nbr_l_kind;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      size_ff <= size_in;
      kind_ff <= kind_in;
   end

   assign key_q  = key_ff;
   assign size_q = size_ff;
   assign kind_q = kind_ff;

endmodule

// ----- hdl/kts_row.sv -----
// The row of cells and the odd/even pairing wiring.
module kts_row #(
   parameter int TABLE_DEPTH = 32,
   parameter int KIND_BITS   = 3,
   parameter int IDX_BITS    = 5,
   parameter int CNT_BITS    = 6
) (
   input  logic                          clock,
   input  kts_pkg::cell_ctl_type         ctl,
   input  logic [IDX_BITS-1:0]           wr_idx,
   input  logic [CNT_BITS-1:0]           fill,
   input  logic [kts_pkg::KEY_BITS-1:0]  wr_key,
   input  logic [kts_pkg::SIZE_BITS-1:0] wr_size,
   input  logic [KIND_BITS-1:0]          wr_kind,
   output logic [TABLE_DEPTH-1:0][kts_pkg::KEY_BITS-1:0]  keys,
   output logic [TABLE_DEPTH-1:0][kts_pkg::SIZE_BITS-1:0] sizes,
   output logic [TABLE_DEPTH-1:0][KIND_BITS-1:0]          kinds
);
   import kts_pkg::*;

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      logic left_ok, right_ok;
      logic [KEY_BITS-1:0]  rk, lk;
      logic [SIZE_BITS-1:0] rs, ls;
      logic [KIND_BITS-1:0] rt, lt;
      // Pair (g, g+1) is active when g has the phase parity and g+1 is held.
      if (g + 1 < TABLE_DEPTH) begin : g_r
         assign left_ok = ((g % 2 == 1) == ctl.odd_phase) &&
                          (CNT_BITS'(g + 1) < fill);
         assign rk = keys[g+1];
         assign rs = sizes[g+1];
         assign rt = kinds[g+1];
      end else begin : g_nr
         assign left_ok = 1'b0;
         assign rk = '0;
         assign rs = '0;
         assign rt = '0;
      end
      if (g > 0) begin : g_l
         assign right_ok = ((g % 2 == 0) == ctl.odd_phase) &&
                           (CNT_BITS'(g) < fill);
         assign lk = keys[g-1];
         assign ls = sizes[g-1];
         assign lt = kinds[g-1];
      end else begin : g_nl
         assign right_ok = 1'b0;
         assign lk = '0;
         assign ls = '0;
         assign lt = '0;
      end
      kts_cell #(.KIND_BITS(KIND_BITS)) u_cell (
         .clock(clock), .ctl(ctl),
         .sel(wr_idx == IDX_BITS'(g)),
         .is_left(left_ok), .is_right(right_ok),
         .wr_key(wr_key), .wr_size(wr_size), .wr_kind(wr_kind),
         .nbr_r_key(rk), .nbr_r_size(rs), .nbr_r_kind(rt),
         .nbr_l_key(lk), .nbr_l_size(ls), .nbr_l_kind(lt),
         .key_q(keys[g]), .size_q(sizes[g]), .kind_q(kinds[g])
      );
   end

endmodule

// ----- hdl/keyed_table_sort_select_core.sv -----
// Channel  | Dir | Handshake             | Content
// req      | in  | req_tvalid/req_tready | tdata: op,key,entry_size,entry_kind,slot,want_count
// rsp      | out | rsp_tvalid/rsp_tready | tdata: status,out_slot,out_key,out_size,out_kind,
//          |     |                       |        entry_total; tlast: last
//
// One operation at a time. Insert and find scan the row one cell per cycle.
// Get and clear need no scan. Sort runs TABLE_DEPTH
// odd-even transposition passes over the row. K-smallest runs a selection scan
// per result, each followed by an emit step; filter is one scan over the
// held entries.
// Reset clears the entry count, the state and the result valid; entries keep
// their contents. A stalled rsp holds the scan until the result register drains.
module keyed_table_sort_select_core #(
   parameter int TABLE_DEPTH = 32,
   parameter int KIND_BITS   = 3
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // op[2:0], key[66:3], entry_size[96:67], entry_kind[99:97], slot[104:100],
   // want_count[110:105], zero pad to 112
   input  logic [111:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // status[2:0], out_slot[7:3], out_key[71:8], out_size[101:72],
   // out_kind[104:102], entry_total[110:105], zero pad to 112
   output logic [111:0]  rsp_tdata,
   output logic          rsp_tlast
);
   import kts_pkg::*;

   localparam int IDX_BITS = $clog2(TABLE_DEPTH);
   localparam int CNT_BITS = $clog2(TABLE_DEPTH + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_SORT = 3'd2;
   localparam logic [2:0] S_SEL  = 3'd3;
   localparam logic [2:0] S_EMIT = 3'd4;
   localparam logic [2:0] S_FILT = 3'd5;

   // request fields
   logic [2:0]           op_w;
   logic [KEY_BITS-1:0]  key_w;
   logic [SIZE_BITS-1:0] size_w;
   logic [2:0]           kind_raw_w;
   logic [4:0]           slot_w;
   logic [5:0]           want_w;
   assign op_w       = req_tdata[2:0];
   assign key_w      = req_tdata[66:3];
   assign size_w     = req_tdata[96:67];
   assign kind_raw_w = req_tdata[99:97];
   assign slot_w     = req_tdata[104:100];
   assign want_w     = req_tdata[110:105];

   logic [2:0]           state_ff, state_in;
   logic [CNT_BITS-1:0]  fill_ff, fill_in;
   logic [2:0]           op_ff, op_in;
   logic [KEY_BITS-1:0]  key_ff, key_in;
   logic [SIZE_BITS-1:0] size_ff, size_in;
   logic [KIND_BITS-1:0] kind_ff, kind_in;
   logic [CNT_BITS-1:0]  want_ff, want_in;
   logic [CNT_BITS-1:0]  idx_ff, idx_in;       // scan pointer
   logic [CNT_BITS-1:0]  done_ff, done_in;     // results given so far
   // previous selection (size, slot) for k-smallest, and current best
   logic [SIZE_BITS-1:0] psz_ff, psz_in, bsz_ff, bsz_in;
   logic [IDX_BITS-1:0]  pix_ff, pix_in, bix_ff, bix_in;
   logic                 have_prev_ff, have_prev_in, have_best_ff, have_best_in;
   logic                 found_ff, found_in;   // filter: a pending match exists
   logic [IDX_BITS-1:0]  pend_ff, pend_in;

   // output register
   logic                 ov_ff, ov_in;
   logic [ST_BITS-1:0]   ost_ff, ost_in;
   logic                 ohas_ff, ohas_in;
   logic [IDX_BITS-1:0]  oix_ff, oix_in;
   logic                 olast_ff, olast_in;

   cell_ctl_type ctl;
   logic [IDX_BITS-1:0] wr_idx;
   logic [TABLE_DEPTH-1:0][KEY_BITS-1:0]  keys;
   logic [TABLE_DEPTH-1:0][SIZE_BITS-1:0] sizes;
   logic [TABLE_DEPTH-1:0][KIND_BITS-1:0] kinds;

   kts_row #(.TABLE_DEPTH(TABLE_DEPTH), .KIND_BITS(KIND_BITS),
             .IDX_BITS(IDX_BITS), .CNT_BITS(CNT_BITS)) u_row (
      .clock(clock), .ctl(ctl), .wr_idx(wr_idx), .fill(fill_ff),
      .wr_key(key_ff), .wr_size(size_ff), .wr_kind(kind_ff),
      .keys(keys), .sizes(sizes), .kinds(kinds)
   );

   logic [IDX_BITS-1:0]  cur;
   logic [KEY_BITS-1:0]  cur_key;
   logic [SIZE_BITS-1:0] cur_size;
   logic [KIND_BITS-1:0] cur_kind;
   logic                 out_free, req_hs;
   logic                 after_prev, better;

   assign cur      = idx_ff[IDX_BITS-1:0];
   assign cur_key  = keys[cur];
   assign cur_size = sizes[cur];
   assign cur_kind = kinds[cur];
   assign out_free = !ov_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign req_hs   = req_tvalid && req_tready;
   assign wr_idx   = fill_ff[IDX_BITS-1:0];

   // Candidate ordering for k-smallest: strictly after the previous pick in
   // (size, slot) order, and better than the current best.
   assign after_prev = !have_prev_ff || (cur_size > psz_ff) ||
                       (cur_size == psz_ff && cur > pix_ff);
   assign better     = !have_best_ff || (cur_size < bsz_ff);

   always_comb begin
      state_in = state_ff; fill_in = fill_ff; op_in = op_ff; key_in = key_ff;
      size_in = size_ff; kind_in = kind_ff; want_in = want_ff; idx_in = idx_ff;
      done_in = done_ff; psz_in = psz_ff; pix_in = pix_ff; bsz_in = bsz_ff;
      bix_in = bix_ff; have_prev_in = have_prev_ff; have_best_in = have_best_ff;
      found_in = found_ff; pend_in = pend_ff;
      ov_in = ov_ff && !rsp_tready; ost_in = ost_ff; ohas_in = ohas_ff;
      oix_in = oix_ff; olast_in = olast_ff;
      ctl = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_hs) begin
               op_in   = op_w;
               key_in  = key_w;
               size_in = size_w;
               kind_in = KIND_BITS'(kind_raw_w);
               want_in = (CNT_BITS'(want_w) > fill_ff || want_w > 6'(TABLE_DEPTH)) ?
                         fill_ff : CNT_BITS'(want_w);
               idx_in  = '0;
               done_in = '0;
               have_prev_in = 1'b0;
               have_best_in = 1'b0;
               found_in = 1'b0;
               ohas_in = 1'b0;
               oix_in  = '0;
               olast_in = 1'b1;
               case (op_w)
                  OP_INSERT, OP_FIND: begin
                     state_in = S_SCAN;
                  end
                  OP_GET: begin
                     ov_in = 1'b1;
                     if ({1'b0, slot_w} >= 6'(fill_ff)) begin
                        ost_in = ST_RANGE;
                     end else begin
                        ost_in = ST_OK; ohas_in = 1'b1;
                        oix_in = IDX_BITS'(slot_w);
                     end
                  end
                  OP_SORT: begin
                     state_in = S_SORT;
                  end
                  OP_KSMALL: begin
                     if (want_w == '0 || fill_ff == '0) begin
                        ov_in = 1'b1; ost_in = ST_NONE;
                     end else begin
                        state_in = S_SEL;
                     end
                  end
                  OP_FILTER: begin
                     state_in = S_FILT;
                  end
                  OP_CLEAR: begin
                     fill_in = '0; ov_in = 1'b1; ost_in = ST_OK;
                  end
                  default: begin
                     ov_in = 1'b1; ost_in = ST_NONE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            // walk one cell per cycle while out_free, looking for the key
            if (out_free) begin
               if (idx_ff < fill_ff && cur_key == key_ff) begin
                  ov_in = 1'b1; state_in = S_IDLE;
                  if (op_ff == OP_FIND) begin
                     ost_in = ST_OK; ohas_in = 1'b1; oix_in = cur;
                  end else if (fill_ff == CNT_BITS'(TABLE_DEPTH)) begin
                     ost_in = ST_FULL;
                  end else begin
                     ost_in = ST_DUP;
                  end
               end else if (idx_ff >= fill_ff) begin
                  ov_in = 1'b1; state_in = S_IDLE;
                  if (op_ff == OP_FIND) begin
                     ost_in = ST_NOTFOUND;
                  end else if (fill_ff == CNT_BITS'(TABLE_DEPTH)) begin
                     ost_in = ST_FULL;
                  end else if (size_ff == '0 || size_ff > SIZE_LIMIT) begin
                     ost_in = ST_BADSIZE;
                  end else begin
                     ctl.write_en = 1'b1;
                     fill_in = fill_ff + 1'b1;
                     ost_in = ST_OK; ohas_in = 1'b1; oix_in = wr_idx;
                  end
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         S_SORT: begin
            ctl.swap_pass = 1'b1;
            ctl.odd_phase = idx_ff[0];
            if (idx_ff == CNT_BITS'(TABLE_DEPTH - 1)) begin
               if (out_free) begin
                  ov_in = 1'b1; ost_in = ST_OK; state_in = S_IDLE;
               end else begin
                  ctl.swap_pass = 1'b0;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_SEL: begin
            // one selection scan: smallest entry after the previous pick
            if (idx_ff < fill_ff) begin
               if (after_prev && better) begin
                  bsz_in = cur_size; bix_in = cur; have_best_in = 1'b1;
               end
               idx_in = idx_ff + 1'b1;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               ov_in = 1'b1; ost_in = ST_OK; ohas_in = 1'b1; oix_in = bix_ff;
               olast_in = (done_ff + 1'b1 == want_ff);
               done_in = done_ff + 1'b1;
               psz_in = bsz_ff; pix_in = bix_ff; have_prev_in = 1'b1;
               have_best_in = 1'b0; idx_in = '0;
               state_in = (done_ff + 1'b1 == want_ff) ? S_IDLE : S_SEL;
            end
         end
         S_FILT: begin
            // hold one match back so the final one can carry last
            if (out_free) begin
               if (idx_ff < fill_ff) begin
                  if (cur_kind == kind_ff) begin
                     if (found_ff) begin
                        ov_in = 1'b1; ost_in = ST_OK; ohas_in = 1'b1;
                        oix_in = pend_ff; olast_in = 1'b0;
                     end
                     found_in = 1'b1; pend_in = cur;
                  end
                  idx_in = idx_ff + 1'b1;
               end else begin
                  ov_in = 1'b1; state_in = S_IDLE; olast_in = 1'b1;
                  if (found_ff) begin
                     ost_in = ST_OK; ohas_in = 1'b1; oix_in = pend_ff;
                  end else begin
                     ost_in = ST_NONE; ohas_in = 1'b0;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff  <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         ov_ff    <= ov_in;
      end
      op_ff <= op_in; key_ff <= key_in; size_ff <= size_in; kind_ff <= kind_in;
      want_ff <= want_in; idx_ff <= idx_in; done_ff <= done_in;
      psz_ff <= psz_in; pix_ff <= pix_in; bsz_ff <= bsz_in; bix_ff <= bix_in;
      have_prev_ff <= have_prev_in; have_best_ff <= have_best_in;
      found_ff <= found_in; pend_ff <= pend_in;
      ost_ff <= ost_in; ohas_ff <= ohas_in; oix_ff <= oix_in; olast_ff <= olast_in;
   end

   // The entry fields are read live from the row; the table does not change
   // while a result waits: writes need out_free, and sort starts only on out_free.
   logic [KEY_BITS-1:0]  ok_w;
   logic [SIZE_BITS-1:0] os_w;
   logic [2:0]           ot_w;
   assign ok_w = ohas_ff ? keys[oix_ff]  : '0;
   assign os_w = ohas_ff ? sizes[oix_ff] : '0;
   assign ot_w = ohas_ff ? 3'(kinds[oix_ff]) : '0;

   assign rsp_tvalid = ov_ff;
   assign rsp_tlast  = olast_ff;
   assign rsp_tdata  = {1'b0, 6'(fill_ff), ot_w, os_w, ok_w,
                        ohas_ff ? 5'(oix_ff) : 5'd0, ost_ff};

endmodule

// ----- hdl/kts_checker.sv -----
module kts_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [111:0] rsp_tdata,
   input logic         rsp_tlast
);
   import kts_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp changed while stalled");
   a_total_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[110:105] <= 6'd32)
      else $error("entry_total out of range");
   a_no_entry_on_err: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] != ST_OK |-> rsp_tdata[104:3] == '0)
      else $error("error result carries entry");
   a_err_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] != ST_OK |-> rsp_tlast)
      else $error("error result not last");
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result after reset");
endmodule

bind keyed_table_sort_select_core kts_checker u_kts_checker (.*);

// ----- test/tb.sv -----
module tb;
   import kts_pkg::*;

   localparam int DEPTH       = 32;
   localparam int RAND_ITEMS  = 460;
   localparam int IDLE_LIMIT  = 20000;
   localparam int HOLD_CYCLES = 300;
   localparam logic [OP_BITS-1:0] OP_UNUSED = 3'd7;

   typedef struct packed {
      logic [5:0]           want;
      logic [4:0]           slot;
      logic [2:0]           kind;
      logic [SIZE_BITS-1:0] size;
      logic [KEY_BITS-1:0]  key;
      logic [OP_BITS-1:0]   op;
   } table_cmd_type;

   typedef struct packed {
      logic [ST_BITS-1:0]   status;
      logic [4:0]           slot;
      logic [KEY_BITS-1:0]  key;
      logic [SIZE_BITS-1:0] size;
      logic [2:0]           kind;
      logic [5:0]           total;
      logic                 last;
   } table_rsp_type;

   // Shadow copy of the table plus the queue of responses it predicts.
   class table_scoreboard;
      logic [KEY_BITS-1:0]  keys  [DEPTH];
      logic [SIZE_BITS-1:0] sizes [DEPTH];
      logic [2:0]           kinds [DEPTH];
      int                   fill;
      table_rsp_type        pending [$];
      int                   mismatches;
      int                   responses;

      function new();
         fill = 0;
         mismatches = 0;
         responses = 0;
      endfunction

      function void push(logic [ST_BITS-1:0] st, int pos, bit has_entry, bit is_last);
         table_rsp_type r;
         r = '0;
         r.status = st;
         if (has_entry) begin
            r.slot = pos[4:0];
            r.key  = keys[pos];
            r.size = sizes[pos];
            r.kind = kinds[pos];
         end
         r.total = fill[5:0];
         r.last  = is_last;
         pending = {pending, r};
      endfunction

      // Stable ascending order of slots by size.
      function void size_order(ref int order[DEPTH]);
         int i, j, v;
         for (i = 0; i < fill; i++) begin
            v = i;
            j = i;
            while (j > 0 && sizes[order[j-1]] > sizes[v]) begin
               order[j] = order[j-1];
               j--;
            end
            order[j] = v;
         end
      endfunction

      function void note(table_cmd_type c);
         int order[DEPTH];
         logic [KEY_BITS-1:0]  k2 [DEPTH];
         logic [SIZE_BITS-1:0] s2 [DEPTH];
         logic [2:0]           t2 [DEPTH];
         int i, want, last_idx, hit;
         hit = -1;
         case (c.op)
            OP_INSERT: begin
               for (i = 0; i < fill; i++) if (hit < 0 && keys[i] == c.key) hit = i;
               if (fill >= DEPTH) push(ST_FULL, 0, 0, 1);
               else if (hit >= 0) push(ST_DUP, 0, 0, 1);
               else if (c.size == 0 || c.size > SIZE_LIMIT) push(ST_BADSIZE, 0, 0, 1);
               else begin
                  keys[fill]  = c.key;
                  sizes[fill] = c.size;
                  kinds[fill] = c.kind;
                  fill++;
                  push(ST_OK, fill - 1, 1, 1);
               end
            end
            OP_FIND: begin
               for (i = 0; i < fill; i++) if (hit < 0 && keys[i] == c.key) hit = i;
               if (hit >= 0) push(ST_OK, hit, 1, 1);
               else push(ST_NOTFOUND, 0, 0, 1);
            end
            OP_GET: begin
               if (int'(c.slot) >= fill) push(ST_RANGE, 0, 0, 1);
               else push(ST_OK, c.slot, 1, 1);
            end
            OP_SORT: begin
               size_order(order);
               for (i = 0; i < fill; i++) begin
                  k2[i] = keys[order[i]];
                  s2[i] = sizes[order[i]];
                  t2[i] = kinds[order[i]];
               end
               for (i = 0; i < fill; i++) begin
                  keys[i]  = k2[i];
                  sizes[i] = s2[i];
                  kinds[i] = t2[i];
               end
               push(ST_OK, 0, 0, 1);
            end
            OP_KSMALL: begin
               want = (int'(c.want) > fill) ? fill : int'(c.want);
               if (want == 0) push(ST_NONE, 0, 0, 1);
               else begin
                  size_order(order);
                  for (i = 0; i < want; i++) push(ST_OK, order[i], 1, i + 1 == want);
               end
            end
            OP_FILTER: begin
               last_idx = -1;
               for (i = 0; i < fill; i++) if (kinds[i] == c.kind) last_idx = i;
               if (last_idx < 0) push(ST_NONE, 0, 0, 1);
               else
                  for (i = 0; i < fill; i++)
                     if (kinds[i] == c.kind) push(ST_OK, i, 1, i == last_idx);
            end
            OP_CLEAR: begin
               fill = 0;
               push(ST_OK, 0, 0, 1);
            end
            default: push(ST_NONE, 0, 0, 1);
         endcase
      endfunction

      function void check(table_rsp_type got);
         table_rsp_type want;
         responses++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected response status=%0d slot=%0d key=%h size=%0d",
                        got.status, got.slot, got.key, got.size);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"ERROR: response %0d expected st=%0d sl=%0d k=%h sz=%0d ",
                         "kd=%0d n=%0d l=%0d got st=%0d sl=%0d k=%h sz=%0d kd=%0d ",
                         "n=%0d l=%0d"},
                        responses, want.status, want.slot, want.key, want.size,
                        want.kind, want.total, want.last, got.status, got.slot,
                        got.key, got.size, got.kind, got.total, got.last);
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [111:0] req_tdata;   // op, key, entry_size, entry_kind, slot, want_count
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [111:0] rsp_tdata;   // status, out_slot, out_key, out_size, out_kind, entry_total
   logic         rsp_tlast;

   table_scoreboard sb;
   bit  hold_request;
   bit  quiet;        // no idling on either side while set
   int  idle_cycles;
   int  cmd_count;
   int  op_seen [8];

   keyed_table_sort_select_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   always begin
      clock = 1'b1; #2;
      clock = 1'b0; #2;
   end

   // Offer one command, entered and left at a falling edge.
   task automatic send_cmd(table_cmd_type c);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {1'b0, c};
      do @(posedge clock); while (!req_tready);
      sb.note(c);
      cmd_count++;
      op_seen[c.op]++;
      @(negedge clock);
   endtask

   function automatic table_cmd_type make_cmd(logic [2:0] op, logic [63:0] key,
                                              logic [29:0] size, logic [2:0] kind,
                                              logic [4:0] slot, logic [5:0] want);
      table_cmd_type c;
      c.op = op; c.key = key; c.size = size; c.kind = kind; c.slot = slot; c.want = want;
      return c;
   endfunction

   function automatic logic [SIZE_BITS-1:0] pick_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return SIZE_BITS'($urandom_range(1, 20));    // many ties
      if (r < 80) return SIZE_BITS'($urandom_range(1, SIZE_LIMIT));
      if (r < 90) case ($urandom_range(0, 3))
         0: return '0;
         1: return 30'd1;
         2: return SIZE_LIMIT;
         default: return SIZE_LIMIT + 30'd1;
      endcase
      return SIZE_BITS'($urandom());
   endfunction

   function automatic logic [KEY_BITS-1:0] pick_key();
      // Reuse a held key now and then to provoke duplicates and hits.
      if (sb.fill > 0 && $urandom_range(0, 3) == 0)
         return sb.keys[$urandom_range(0, sb.fill - 1)];
      if ($urandom_range(0, 4) == 0) return KEY_BITS'($urandom_range(0, 15));
      return {$urandom(), $urandom()};
   endfunction

   function automatic table_cmd_type random_cmd();
      table_cmd_type c;
      int r;
      c = make_cmd(OP_INSERT, pick_key(), pick_size(), 3'($urandom_range(0, 7)),
                   5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)));
      r = $urandom_range(0, 99);
      if (r < 40)      c.op = OP_INSERT;
      else if (r < 55) c.op = OP_FIND;
      else if (r < 65) c.op = OP_GET;
      else if (r < 72) c.op = OP_SORT;
      else if (r < 82) c.op = OP_KSMALL;
      else if (r < 93) c.op = OP_FILTER;
      else if (r < 96) c.op = OP_CLEAR;
      else             c.op = OP_UNUSED;
      if (c.op == OP_GET && sb.fill > 0 && $urandom_range(0, 3) != 0)
         c.slot = 5'($urandom_range(0, sb.fill - 1));
      return c;
   endfunction

   // Response side: random stalls, one long hold-off on request.
   initial begin
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_request) begin
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end else if (!quiet) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check({rsp_tdata[2:0], rsp_tdata[7:3], rsp_tdata[71:8], rsp_tdata[101:72],
                   rsp_tdata[104:102], rsp_tdata[110:105], rsp_tlast});
         @(negedge clock);
      end
   end

   // Watchdog: count cycles with no transaction on either channel.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
         $display("FAIL keyed_table_sort_select_core");
         $finish;
      end
   end

   initial begin
      table_cmd_type c;
      int i;
      sb = new();
      hold_request = 1'b0;
      quiet = 1'b0;
      cmd_count = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      // Directed: empty table, field extremes, each error path except a full table.
      send_cmd(make_cmd(OP_KSMALL, 0, 0, 0, 0, 6'd5));
      send_cmd(make_cmd(OP_FILTER, 0, 0, 3'd0, 0, 0));
      send_cmd(make_cmd(OP_GET, 0, 0, 0, 5'd0, 0));
      send_cmd(make_cmd(OP_SORT, 0, 0, 0, 0, 0));
      send_cmd(make_cmd(OP_INSERT, '0, 30'd1, 3'd0, 0, 0));
      send_cmd(make_cmd(OP_INSERT, '1, SIZE_LIMIT, 3'd7, 5'd31, 6'd63));
      send_cmd(make_cmd(OP_INSERT, '0, 30'd5, 3'd2, 0, 0));
      send_cmd(make_cmd(OP_INSERT, 64'd9, 30'd0, 3'd2, 0, 0));
      send_cmd(make_cmd(OP_INSERT, 64'd9, SIZE_LIMIT + 30'd1, 3'd2, 0, 0));
      send_cmd(make_cmd(OP_INSERT, 64'd9, 30'h3fffffff, 3'd2, 0, 0));
      send_cmd(make_cmd(OP_INSERT, 64'd7, 30'd1, 3'd7, 0, 0));
      send_cmd(make_cmd(OP_INSERT, 64'hA5A5_5A5A_F0F0_0F0F, 30'd3, 3'd5, 0, 0));
      send_cmd(make_cmd(OP_FIND, '1, 0, 0, 0, 0));
      send_cmd(make_cmd(OP_FIND, 64'd1234, 0, 0, 0, 0));
      send_cmd(make_cmd(OP_GET, 0, 0, 0, 5'd3, 0));
      send_cmd(make_cmd(OP_GET, 0, 0, 0, 5'd31, 0));
      send_cmd(make_cmd(OP_KSMALL, 0, 0, 0, 0, 6'd0));
      send_cmd(make_cmd(OP_KSMALL, 0, 0, 0, 0, 6'd63));
      send_cmd(make_cmd(OP_FILTER, 0, 0, 3'd7, 0, 0));
      send_cmd(make_cmd(OP_FILTER, 0, 0, 3'd4, 0, 0));
      send_cmd(make_cmd(OP_SORT, 0, 0, 0, 0, 0));
      send_cmd(make_cmd(OP_GET, 0, 0, 0, 5'd0, 0));
      send_cmd(make_cmd(OP_UNUSED, '1, '1, '1, '1, '1));
      send_cmd(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0));
      send_cmd(make_cmd(OP_GET, 0, 0, 0, 5'd0, 0));

      for (i = 0; i < RAND_ITEMS; i++) begin
         quiet = (i >= 200 && i < 240);
         if (i == 120) hold_request = 1'b1;
         if (i == 300) begin
            // Drain completely before going on.
            req_tvalid = 1'b0;
            while (sb.pending.size() != 0) @(negedge clock);
         end
         c = random_cmd();
         send_cmd(c);
      end
      req_tvalid = 1'b0;
      quiet = 1'b0;

      while (sb.pending.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);

      $display("covered %0d commands (ins %0d find %0d get %0d sort %0d ksm %0d",
               cmd_count, op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4]);
      $display("  flt %0d clr %0d other %0d), checked %0d responses, %0d mismatches",
               op_seen[5], op_seen[6], op_seen[7], sb.responses, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending.size() == 0)
         $display("PASS keyed_table_sort_select_core");
      else
         $display("FAIL keyed_table_sort_select_core");
      $finish;
   end
endmodule
